// ===== hw/rtl/ppt2d_pkg.sv =====
// ----------------------------------------------------------------------------
// ppt2d_pkg
// Shared constants, tables and types for the 2D pose point transform.
// ----------------------------------------------------------------------------
package ppt2d_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int FRACTION_BITS = 16;

  // datapath widths
  localparam int XW = 32 + FRACTION_BITS + 3;  // rotation x/y with guard bits
  localparam int ZW = 33;                      // residual angle
  localparam int RW = XW - FRACTION_BITS;      // rounded coordinate
  localparam int GAIN_SHIFT = 32 - FRACTION_BITS;

  // 1/1.6467602 in Q0.32
  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

  // 360 degrees in Q10.16, and the reciprocal of 45 for the binary angle scale
  localparam logic [24:0] DEG_FULL_TURN = 25'd23592960;
  localparam logic [25:0] RECIP_45      = 26'd47721859;  // ceil(2^31 / 45)
  localparam int          RECIP_SHIFT   = 31;
  localparam int          QW            = 19;            // quotient of r / 45

  // configuration register indexes
  localparam logic [1:0] REG_POSE_X  = 2'd0;
  localparam logic [1:0] REG_POSE_Y  = 2'd1;
  localparam logic [1:0] REG_HEADING = 2'd2;

  typedef logic [31:0] atan_tbl_t [32];
  typedef logic [12:0] frac_tbl_t [64];

  // atan(2^-i) in binary angle units, 2^32 per turn
  localparam atan_tbl_t ATAN_TBL = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // floor((b * 8192 + 22) / 45) for a remainder b of the division by 45
  function automatic frac_tbl_t build_frac_tbl();
    frac_tbl_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = (i < 45) ? 13'((i * 8192 + 22) / 45) : 13'd0;
    end
    return t;
  endfunction

  localparam frac_tbl_t FRAC_TBL = build_frac_tbl();

endpackage

// ===== hw/rtl/pose_point_transform_2d_unit.sv =====
// ----------------------------------------------------------------------------
// pose_point_transform_2d_unit
// Rotates a robot-frame point by the heading and adds the pose position.
// ----------------------------------------------------------------------------
// Usage:
//   Points enter on the s_axis channel, one per transaction, and leave on
//   m_axis in the same order, one result per point. The pose registers are
//   written through cfg_we / cfg_index / cfg_data while no point is in flight.
//   The pipeline has two multiply stages for gain and angle scaling, two
//   stages for the binary angle and half-plane fold, one stage per CORDIC
//   iteration, then rounding and the saturating pose add. Throughput is one
//   point per cycle while m_axis_tready is high; every stage is a register
//   with its own valid bit.
//   When m_axis_tready is low the output stage holds and empty stages in
//   front of it still fill, so s_axis_tready drops only once the pipeline
//   is full. Nothing is dropped or repeated.
//   Reset (rst, synchronous) empties the pipeline and clears the pose and
//   heading registers to zero.
// ----------------------------------------------------------------------------
module pose_point_transform_2d_unit
  import ppt2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] local_x, [63:32] local_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] global_x, [63:32] global_y
  output logic        m_axis_tuser    // [0] saturated
);

  localparam int NS = CORDIC_STAGES + 6;
  localparam int SR = CORDIC_STAGES + 4;  // rounding stage
  localparam int SO = CORDIC_STAGES + 5;  // output stage

  // configuration
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [25:0] heading_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x      <= '0;
      pose_y      <= '0;
      heading_deg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POSE_X:  pose_x      <= cfg_data;
        REG_POSE_Y:  pose_y      <= cfg_data;
        REG_HEADING: heading_deg <= cfg_data[25:0];
        default: ;
      endcase
    end
  end

  // valid / ready chain: a stage loads when empty or when its successor loads
  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  assign rdy[NS]        = m_axis_tready;
  assign rdy[NS-1:0]    = ~vld | rdy[NS:1];
  assign s_axis_tready  = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 0: gain multiply, heading reduced modulo 360
  logic signed [31:0] local_x;
  logic signed [31:0] local_y;
  logic signed [64:0] prod_x;
  logic signed [64:0] prod_y;
  logic signed [26:0] hx;
  logic signed [26:0] h_minus;
  logic signed [26:0] h_plus;
  logic signed [26:0] h_plus2;
  logic signed [26:0] h_red;
  logic signed [26:0] turn_s;

  assign local_x = s_axis_tdata[31:0];
  assign local_y = s_axis_tdata[63:32];
  assign prod_x  = $signed(local_x) * $signed({1'b0, GAIN_Q32});
  assign prod_y  = $signed(local_y) * $signed({1'b0, GAIN_Q32});

  assign turn_s  = $signed({2'b00, DEG_FULL_TURN});
  assign hx      = {heading_deg[25], heading_deg};
  assign h_minus = hx - turn_s;
  assign h_plus  = hx + turn_s;
  assign h_plus2 = hx + (turn_s <<< 1);

  always_comb begin
    if (hx >= turn_s) begin
      h_red = h_minus;
    end else if (hx >= 27'sd0) begin
      h_red = hx;
    end else if (h_plus >= 27'sd0) begin
      h_red = h_plus;
    end else begin
      h_red = h_plus2;
    end
  end

  logic signed [63:0] px0;
  logic signed [63:0] py0;
  logic [24:0]        r0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      px0 <= prod_x[63:0];
      py0 <= prod_y[63:0];
      r0  <= h_red[24:0];
    end
  end

  // stage 1: quotient r / 45 by reciprocal, drop gain fraction bits
  logic [50:0]        qprod;
  logic signed [63:0] sx0;
  logic signed [63:0] sy0;

  assign qprod = {26'd0, r0} * {25'd0, RECIP_45};
  assign sx0   = px0 >>> GAIN_SHIFT;
  assign sy0   = py0 >>> GAIN_SHIFT;

  logic [QW-1:0]      q1;
  logic [24:0]        r1;
  logic signed [XW-1:0] x1;
  logic signed [XW-1:0] y1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      q1 <= qprod[RECIP_SHIFT+QW-1:RECIP_SHIFT];
      r1 <= r0;
      x1 <= sx0[XW-1:0];
      y1 <= sy0[XW-1:0];
    end
  end

  // stage 2: remainder of r / 45
  logic [24:0] qm;
  logic [24:0] rem;

  assign qm  = {{(25-QW){1'b0}}, q1} * 25'd45;
  assign rem = r1 - qm;

  logic [QW-1:0]        q2;
  logic [5:0]           b2;
  logic signed [XW-1:0] x2;
  logic signed [XW-1:0] y2;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      q2 <= q1;
      b2 <= rem[5:0];
      x2 <= x1;
      y2 <= y1;
    end
  end

  // stage 3: binary angle, fold the rear half plane by 180 degrees
  logic [31:0] ang;
  logic        fold;
  logic [31:0] ang_f;

  assign ang   = {q2, 13'd0} + {19'd0, FRAC_TBL[b2]};
  assign fold  = ang[31] ^ ang[30];
  assign ang_f = {ang[31] ^ fold, ang[30:0]};

  logic signed [XW-1:0] cx [CORDIC_STAGES+1];
  logic signed [XW-1:0] cy [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz [CORDIC_STAGES+1];
  logic signed [XW-1:0] nx [CORDIC_STAGES];
  logic signed [XW-1:0] ny [CORDIC_STAGES];
  logic signed [ZW-1:0] nz [CORDIC_STAGES];

  // CORDIC rotation, one iteration per stage
  always_comb begin
    for (int k = 0; k < CORDIC_STAGES; k++) begin
      if (!cz[k][ZW-1]) begin
        nx[k] = cx[k] - (cy[k] >>> k);
        ny[k] = cy[k] + (cx[k] >>> k);
        nz[k] = cz[k] - $signed({1'b0, ATAN_TBL[k]});
      end else begin
        nx[k] = cx[k] + (cy[k] >>> k);
        ny[k] = cy[k] - (cx[k] >>> k);
        nz[k] = cz[k] + $signed({1'b0, ATAN_TBL[k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      cx[0] <= fold ? -x2 : x2;
      cy[0] <= fold ? -y2 : y2;
      cz[0] <= $signed({ang_f[31], ang_f});
    end
    for (int k = 0; k < CORDIC_STAGES; k++) begin
      if (rdy[4+k]) begin
        cx[k+1] <= nx[k];
        cy[k+1] <= ny[k];
        cz[k+1] <= nz[k];
      end
    end
  end

  // round half up to Q16.16
  localparam logic signed [XW-1:0] HALF = XW'(1) <<< (FRACTION_BITS - 1);

  logic signed [XW-1:0] xh;
  logic signed [XW-1:0] yh;
  logic signed [RW-1:0] xr;
  logic signed [RW-1:0] yr;

  assign xh = cx[CORDIC_STAGES] + HALF;
  assign yh = cy[CORDIC_STAGES] + HALF;

  always_ff @(posedge clk) begin
    if (rdy[SR]) begin
      xr <= xh[XW-1:FRACTION_BITS];
      yr <= yh[XW-1:FRACTION_BITS];
    end
  end

  // add pose, clamp to the 32-bit range
  logic signed [RW:0] sum_x;
  logic signed [RW:0] sum_y;
  logic               ovf_x;
  logic               ovf_y;
  logic [31:0]        clip_x;
  logic [31:0]        clip_y;

  assign sum_x  = {xr[RW-1], xr} + (RW+1)'(pose_x);
  assign sum_y  = {yr[RW-1], yr} + (RW+1)'(pose_y);
  assign ovf_x  = (sum_x[RW:31] != {(RW-30){sum_x[31]}});
  assign ovf_y  = (sum_y[RW:31] != {(RW-30){sum_y[31]}});
  assign clip_x = ovf_x ? (sum_x[RW] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_x[31:0];
  assign clip_y = ovf_y ? (sum_y[RW] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_y[31:0];

  logic [31:0] out_x;
  logic [31:0] out_y;
  logic        out_sat;

  always_ff @(posedge clk) begin
    if (rdy[SO]) begin
      out_x   <= clip_x;
      out_y   <= clip_y;
      out_sat <= ovf_x | ovf_y;
    end
  end

  assign m_axis_tvalid = vld[NS-1];
  assign m_axis_tdata  = {out_y, out_x};
  assign m_axis_tuser  = out_sat;

endmodule
